// ===== hdl/ctcbs_pkg.sv =====
// ----------------------------------------------------------------------------
// ctcbs_pkg
// Shared constants and types of the CTC beam search step block.
// ----------------------------------------------------------------------------
package ctcbs_pkg;

  localparam int BEAM_MAX         = 16;
  localparam int SLOT_W           = 4;
  localparam int CNT_W            = 5;
  localparam int CLASS_INDEX_BITS = 16;
  localparam int IN_SCORE_W       = 24;
  localparam int SCORE_W          = 32;
  localparam int CFG_INDEX_W      = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_BEAM_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLANK_INDEX = 8'd1;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef score_t [BEAM_MAX-1:0]     score_arr_t;

  // Per-slot decisions of one sorted insert.
  typedef struct packed {
    logic [BEAM_MAX-1:0] wr_new;
    logic [BEAM_MAX-1:0] shift;
  } ins_ctl_t;

endpackage

// ===== hdl/ctcbs_if.sv =====
// ----------------------------------------------------------------------------
// ctcbs interfaces
// Valid/ready channels for class scores, beam results and register writes.
// ----------------------------------------------------------------------------
interface ctcbs_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] class_score;
  logic               frame_end;
  logic               utterance_end;
  modport source (output valid, class_score, frame_end, utterance_end, input ready);
  modport sink   (input valid, class_score, frame_end, utterance_end, output ready);
endinterface

interface ctcbs_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         beam_slot;
  logic [3:0]         parent_slot;
  logic [15:0]        token_index;
  logic               appended;
  logic signed [31:0] beam_score;
  logic               last_of_frame;
  modport source (output valid, beam_slot, parent_slot, token_index, appended, beam_score,
                  last_of_frame, input ready);
  modport sink   (input valid, beam_slot, parent_slot, token_index, appended, beam_score,
                  last_of_frame, output ready);
endinterface

interface ctcbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/ctc_beam_search_step.sv =====
// ----------------------------------------------------------------------------
// ctc_beam_search_step
// Non-prefix CTC beam search step with a running top-K class list.
// ----------------------------------------------------------------------------
// Usage: class scores of a frame enter on item_in, one item per class in
// ascending class order. Each is sorted into the top-K class list in the
// cycle it is accepted, so within a frame the block takes one item a cycle.
// The item with frame_end starts the expansion: K*K extensions go through one
// shared adder and one shared sorted-insert unit, each extension taking an add
// step and an insert step, and then the block offers K result items on
// beam_out, best first, with last_of_frame on the K-th. A stalled receiver
// simply holds the result in place; no new item is taken until all K are
// delivered and the beams have been updated. Registers are written
// on cfg (index 0 beam width, index 1 blank index), which is always ready.
// Reset (rst, synchronous) sets width 10, blank 0, zero beam scores, no
// previous tokens, and an empty class list.
// ----------------------------------------------------------------------------
module ctc_beam_search_step (
  input  logic clk,
  input  logic rst,
  ctcbs_in_if.sink    item_in,
  ctcbs_out_if.source beam_out,
  ctcbs_cfg_if.sink   cfg
);
  import ctcbs_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADD  = 3'd1;
  localparam logic [2:0] ST_INS  = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic signed [IN_SCORE_W-1:0] IN_MIN = {1'b1, {(IN_SCORE_W-1){1'b0}}};
  localparam logic [CLASS_INDEX_BITS:0] NONE_TOKEN = {1'b1, {CLASS_INDEX_BITS{1'b0}}};

  logic [2:0]                  state;
  logic [CNT_W-1:0]            beam_width;
  logic [CLASS_INDEX_BITS-1:0] blank_index;

  logic signed [SCORE_W-1:0]    beam_scores [BEAM_MAX];
  logic [CLASS_INDEX_BITS:0]    beam_last   [BEAM_MAX];
  logic signed [IN_SCORE_W-1:0] top_scores  [BEAM_MAX];
  logic [CLASS_INDEX_BITS-1:0]  top_idx     [BEAM_MAX];
  logic [CLASS_INDEX_BITS-1:0]  class_counter;

  logic signed [SCORE_W-1:0]   nsc  [BEAM_MAX];
  logic [SLOT_W-1:0]           npar [BEAM_MAX];
  logic [CLASS_INDEX_BITS-1:0] ntok [BEAM_MAX];

  logic [SLOT_W-1:0]         ci, bj, r;
  logic [CNT_W-1:0]          cnt;
  logic                      uend;
  logic signed [SCORE_W-1:0] sum;

  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] fill_top;
  logic [SLOT_W-1:0] k_last;
  score_arr_t       unit_list;
  score_t           unit_score;
  logic [CNT_W-1:0] unit_fill;
  ins_ctl_t         ctl;
  logic             in_acc;
  logic [SCORE_W:0] wide_sum;

  always_comb begin
    if (beam_width == '0) k = CNT_W'(1);
    else if (beam_width > CNT_W'(BEAM_MAX)) k = CNT_W'(BEAM_MAX);
    else k = beam_width;
  end
  assign k_last = SLOT_W'(k - CNT_W'(1));

  assign fill_top = (class_counter < CLASS_INDEX_BITS'(k)) ? class_counter[CNT_W-1:0] : k;

  assign item_in.ready = (state == ST_IDLE);
  assign in_acc        = item_in.valid && item_in.ready;
  assign cfg.ready     = 1'b1;

  // The insert unit serves the class list at intake and the beam list during expansion.
  always_comb begin
    for (int q = 0; q < BEAM_MAX; q++) begin
      unit_list[q] = (state == ST_INS) ? nsc[q] : SCORE_W'(top_scores[q]);
    end
    unit_score = (state == ST_INS) ? sum : SCORE_W'(item_in.class_score);
    unit_fill  = (state == ST_INS) ? cnt : fill_top;
  end

  ctcbs_insert u_insert (
    .list  (unit_list),
    .score (unit_score),
    .fill  (unit_fill),
    .width (k),
    .ctl   (ctl)
  );

  assign wide_sum = {beam_scores[bj][SCORE_W-1], beam_scores[bj]}
                  + (SCORE_W+1)'(top_scores[ci]);

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_width  <= CNT_W'(10);
      blank_index <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == REG_BEAM_WIDTH) beam_width <= cfg.data[CNT_W-1:0];
      else if (cfg.index == REG_BLANK_INDEX) blank_index <= cfg.data[CLASS_INDEX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      class_counter <= '0;
      ci   <= '0;
      bj   <= '0;
      r    <= '0;
      cnt  <= '0;
      uend <= 1'b0;
      for (int q = 0; q < BEAM_MAX; q++) begin
        beam_scores[q] <= '0;
        beam_last[q]   <= NONE_TOKEN;
        top_scores[q]  <= IN_MIN;
        top_idx[q]     <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            for (int q = 0; q < BEAM_MAX; q++) begin
              if (ctl.wr_new[q]) begin
                top_scores[q] <= item_in.class_score;
                top_idx[q]    <= class_counter;
              end
            end
            for (int q = 1; q < BEAM_MAX; q++) begin
              if (ctl.shift[q]) begin
                top_scores[q] <= top_scores[q-1];
                top_idx[q]    <= top_idx[q-1];
              end
            end
            if (class_counter != '1) class_counter <= class_counter + 1'b1;
            if (item_in.frame_end) begin
              uend  <= item_in.utterance_end;
              ci    <= '0;
              bj    <= '0;
              cnt   <= '0;
              state <= ST_ADD;
            end
          end
        end
        ST_ADD: begin
          if (wide_sum[SCORE_W] != wide_sum[SCORE_W-1])
            sum <= wide_sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
                                     : {1'b0, {(SCORE_W-1){1'b1}}};
          else
            sum <= wide_sum[SCORE_W-1:0];
          state <= ST_INS;
        end
        ST_INS: begin
          if (cnt < k) cnt <= cnt + 1'b1;
          state <= ST_ADD;
          if (bj == k_last) begin
            bj <= '0;
            if (ci == k_last) begin
              r     <= '0;
              state <= ST_EMIT;
            end else begin
              ci <= ci + 1'b1;
            end
          end else begin
            bj <= bj + 1'b1;
          end
        end
        ST_EMIT: begin
          if (beam_out.ready) begin
            if (r == k_last) state <= ST_FIN;
            else r <= r + 1'b1;
          end
        end
        ST_FIN: begin
          for (int q = 0; q < BEAM_MAX; q++) begin
            if (uend) begin
              beam_scores[q] <= '0;
              beam_last[q]   <= NONE_TOKEN;
            end else if (CNT_W'(q) < k) begin
              beam_scores[q] <= nsc[q];
              beam_last[q]   <= {1'b0, ntok[q]};
            end
            top_scores[q] <= IN_MIN;
            top_idx[q]    <= '0;
          end
          class_counter <= '0;
          state         <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // New-beam list: payload only, filled by the shared insert unit.
  always_ff @(posedge clk) begin
    if (state == ST_INS) begin
      for (int q = 0; q < BEAM_MAX; q++) begin
        if (ctl.wr_new[q]) begin
          nsc[q]  <= sum;
          npar[q] <= bj;
          ntok[q] <= top_idx[ci];
        end
      end
      for (int q = 1; q < BEAM_MAX; q++) begin
        if (ctl.shift[q]) begin
          nsc[q]  <= nsc[q-1];
          npar[q] <= npar[q-1];
          ntok[q] <= ntok[q-1];
        end
      end
    end
  end

  assign beam_out.valid         = (state == ST_EMIT);
  assign beam_out.beam_slot     = r;
  assign beam_out.parent_slot   = npar[r];
  assign beam_out.token_index   = ntok[r];
  assign beam_out.appended      = (ntok[r] != blank_index)
                               && ({1'b0, ntok[r]} != beam_last[npar[r]]);
  assign beam_out.beam_score    = nsc[r];
  assign beam_out.last_of_frame = (r == k_last);

endmodule

// ===== hdl/ctcbs_insert.sv =====
// ----------------------------------------------------------------------------
// ctcbs_insert
// Sorted-insert decision unit shared by the class list and the beam list.
// ----------------------------------------------------------------------------
module ctcbs_insert (
  input  ctcbs_pkg::score_arr_t       list,
  input  ctcbs_pkg::score_t           score,
  input  logic [ctcbs_pkg::CNT_W-1:0] fill,
  input  logic [ctcbs_pkg::CNT_W-1:0] width,
  output ctcbs_pkg::ins_ctl_t         ctl
);
  import ctcbs_pkg::*;

  logic [BEAM_MAX-1:0] stay;
  logic [BEAM_MAX:0]   prev;

  // Entries that the new score does not beat form a prefix of the list.
  always_comb begin
    prev[0] = 1'b1;
    for (int q = 0; q < BEAM_MAX; q++) begin
      stay[q]       = (CNT_W'(q) < fill) && !(score > list[q]);
      prev[q+1]     = stay[q];
      ctl.wr_new[q] = prev[q] && !stay[q] && (CNT_W'(q) <= fill) && (CNT_W'(q) < width);
      ctl.shift[q]  = (q != 0) && !prev[q] && (CNT_W'(q) <= fill) && (CNT_W'(q) < width);
    end
  end

endmodule
